[rtl/elrp_pkg.sv]
// ----------------------------------------------------------------------------
// elrp_pkg
// Shared types and constants of the event remap and packing block
// ----------------------------------------------------------------------------
package elrp_pkg;

	localparam int TABLE_DEPTH  = 524288;
	localparam int PACKET_WORDS = 64;
	localparam int TARGET_SLOTS = 2;

	localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W   = (PACKET_WORDS > 1) ? $clog2(PACKET_WORDS) : 1;
	// wide enough for x * height + y with 10-bit operands
	localparam int IDX_W   = 20;
	localparam int COORD_W = 10;

	// table depth as a number that can be compared against a 21-bit index
	localparam logic [IDX_W:0] DEPTH_L = (IDX_W + 1)'(TABLE_DEPTH);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PACKET_WORDS - 1);

	localparam logic [9:0] HEIGHT_RESET = 10'd480;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_EVENT = 1'b1;

	typedef struct packed {
		logic               vld;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} slot_t;

	typedef slot_t [TARGET_SLOTS-1:0] entry_t;

	// marker bit 31, column at 25..16, polarity bit 15, row at 9..0
	function automatic logic [31:0] pack_word(input slot_t s);
		return {1'b1, 5'b0, s.x, 1'b1, 5'b0, s.y};
	endfunction

endpackage

[rtl/elrp_if.sv]
// ----------------------------------------------------------------------------
// elrp channel interfaces
// Input item channel and result word channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface elrp_in_if;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic [9:0]         event_x;
	logic [9:0]         event_y;
	logic [18:0]        entry_index;
	logic signed [10:0] first_target_x;
	logic signed [10:0] first_target_y;
	logic signed [10:0] second_target_x;
	logic signed [10:0] second_target_y;

	modport source (
		output valid, cmd, event_x, event_y, entry_index,
		       first_target_x, first_target_y, second_target_x, second_target_y,
		input  ready
	);
	modport sink (
		input  valid, cmd, event_x, event_y, entry_index,
		       first_target_x, first_target_y, second_target_x, second_target_y,
		output ready
	);
endinterface

interface elrp_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] packed_word;
	logic        last_of_event;
	logic        end_of_packet;

	modport source (
		output valid, packed_word, last_of_event, end_of_packet,
		input  ready
	);
	modport sink (
		input  valid, packed_word, last_of_event, end_of_packet,
		output ready
	);
endinterface

[rtl/elrp_emit.sv]
// ----------------------------------------------------------------------------
// elrp_emit
// Walks the valid slots of one table entry, packs words, counts packets
// ----------------------------------------------------------------------------
module elrp_emit
	import elrp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  entry_t            ent,
	output logic              take,
	elrp_out_if.source        out_ch
);

	logic                    busy_q;
	logic [TARGET_SLOTS-1:0] pend_q;
	logic                    ovalid_q;
	logic [31:0]             word_q;
	logic                    last_q;
	logic                    eop_q;
	logic [CNT_W-1:0]        cnt_q;

	logic [TARGET_SLOTS-1:0] vld;
	logic [TARGET_SLOTS-1:0] pend;
	logic [TARGET_SLOTS-1:0] pick;
	logic [TARGET_SLOTS-1:0] rem;
	slot_t                   slot;
	logic                    out_free;
	logic                    emit;
	logic                    eop;

	always_comb begin
		for (int k = 0; k < TARGET_SLOTS; k++) begin
			vld[k] = ent[k].vld;
		end
		pend = busy_q ? (pend_q & vld) : '0;
		// lowest pending slot goes first
		pick = '0;
		slot = ent[0];
		for (int k = TARGET_SLOTS - 1; k >= 0; k--) begin
			if (pend[k]) begin
				pick    = '0;
				pick[k] = 1'b1;
				slot    = ent[k];
			end
		end
		rem      = pend & ~pick;
		out_free = !ovalid_q || out_ch.ready;
		emit     = out_free && (pend != '0);
		take     = (pend == '0) || (emit && (rem == '0));
		eop      = (cnt_q == CNT_LAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			pend_q   <= '0;
			ovalid_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (take) begin
				busy_q <= load;
				pend_q <= '1;
			end else if (emit) begin
				pend_q <= rem;
			end
			if (emit) begin
				ovalid_q <= 1'b1;
				cnt_q    <= eop ? '0 : cnt_q + 1'b1;
			end else if (out_ch.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			word_q <= pack_word(slot);
			last_q <= (rem == '0);
			eop_q  <= eop;
		end
	end

	assign out_ch.valid         = ovalid_q;
	assign out_ch.packed_word   = word_q;
	assign out_ch.last_of_event = last_q;
	assign out_ch.end_of_packet = eop_q;

endmodule

[rtl/event_lut_remap_packer_top.sv]
// ----------------------------------------------------------------------------
// event_lut_remap_packer_top
// Undistortion table remap of sensor events into packed 32-bit words
// ----------------------------------------------------------------------------
//  channel   dir  handshake      contents
//  in_ch     in   valid/ready    cmd, event coords, table entry load data
//  out_ch    out  valid/ready    packed_word, last_of_event, end_of_packet
//  cfg       in   cfg_we         cfg_wdata = sensor_height
//
// loads bypass the emitter; an event with at most one target frees it with
// its word, if any, while one with two targets holds the emit stage until its
// second word enters the single output register. words pass the stage 1,
// stage 2 and table read registers before it. reset sets height to 480 and
// the word counter to zero; the table has no clearing pass and holds garbage
// until each entry is loaded. in_ch.ready falls only when every stage is full
// and the emitter cannot take a new entry.
module event_lut_remap_packer_top
	import elrp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [9:0] cfg_wdata,
	elrp_in_if.sink    in_ch,
	elrp_out_if.source out_ch
);

	logic [9:0] height_q;

	// stage 1: registered input item
	logic               v_s1;
	logic               cmd_s1;
	logic [9:0]         x_s1;
	logic [9:0]         y_s1;
	logic [18:0]        eidx_s1;
	logic signed [10:0] tx0_s1;
	logic signed [10:0] ty0_s1;
	logic signed [10:0] tx1_s1;
	logic signed [10:0] ty1_s1;

	// stage 2: memory access
	logic              we_s2;
	logic              re_s2;
	logic [ADDR_W-1:0] addr_s2;
	entry_t            wdata_s2;

	entry_t mem [TABLE_DEPTH];
	entry_t rd_q;

	logic [IDX_W-1:0] prod;
	logic [IDX_W-1:0] idx;
	logic [IDX_W-1:0] eidx_w;
	logic             ev_ok;
	logic             ld_ok;
	entry_t           wr_ent;
	logic             take;
	logic             rd_en;
	logic             adv1;
	logic             adv2;

	always_comb begin
		prod   = IDX_W'(x_s1) * IDX_W'(height_q);
		idx    = prod + IDX_W'(y_s1);
		eidx_w = IDX_W'(eidx_s1);
		ev_ok  = {1'b0, idx} < DEPTH_L;
		ld_ok  = {1'b0, eidx_w} < DEPTH_L;
		wr_ent = '0;
		wr_ent[0].vld = !tx0_s1[10];
		wr_ent[0].x   = tx0_s1[9:0];
		wr_ent[0].y   = ty0_s1[9:0];
		if (TARGET_SLOTS > 1) begin
			wr_ent[TARGET_SLOTS-1].vld = !tx1_s1[10];
			wr_ent[TARGET_SLOTS-1].x   = tx1_s1[9:0];
			wr_ent[TARGET_SLOTS-1].y   = ty1_s1[9:0];
		end
	end

	// a load in stage 2 never waits on the emitter; only a read needs a free emit stage
	assign rd_en       = re_s2 && take;
	assign adv2        = take || !re_s2;
	assign adv1        = adv2 || !v_s1;
	assign in_ch.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= HEIGHT_RESET;
			v_s1     <= 1'b0;
			we_s2    <= 1'b0;
			re_s2    <= 1'b0;
		end else begin
			if (cfg_we) begin
				height_q <= cfg_wdata;
			end
			if (adv1) begin
				v_s1 <= in_ch.valid;
			end
			if (adv2) begin
				we_s2 <= v_s1 && (cmd_s1 == CMD_LOAD) && ld_ok;
				re_s2 <= v_s1 && (cmd_s1 == CMD_EVENT) && ev_ok;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			cmd_s1  <= in_ch.cmd;
			x_s1    <= in_ch.event_x;
			y_s1    <= in_ch.event_y;
			eidx_s1 <= in_ch.entry_index;
			tx0_s1  <= in_ch.first_target_x;
			ty0_s1  <= in_ch.first_target_y;
			tx1_s1  <= in_ch.second_target_x;
			ty1_s1  <= in_ch.second_target_y;
		end
		if (adv2) begin
			addr_s2  <= (cmd_s1 == CMD_LOAD) ? eidx_w[ADDR_W-1:0] : idx[ADDR_W-1:0];
			wdata_s2 <= wr_ent;
		end
	end

	// single port: a write lands before any later item reaches this stage,
	// so a read always sees the latest load of its entry
	always_ff @(posedge clk) begin
		if (we_s2) begin
			mem[addr_s2] <= wdata_s2;
		end
		if (rd_en) begin
			rd_q <= mem[addr_s2];
		end
	end

	elrp_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (rd_en),
		.ent    (rd_q),
		.take   (take),
		.out_ch (out_ch)
	);

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> (v_s1 && re_s2 && !take))
		else $error("input stalled with a free stage");

	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		we_s2 |-> !rd_en)
		else $error("table written and read in one cycle");

	a_read_fills: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> !$past(v_s1 && !adv1))
		else $error("table read while input side stuck");

endmodule
